FILE: design/cldw_pkg.sv
`timescale 1ns / 1ps

package cldw_pkg;

    // display geometry defaults
    localparam int DEF_COLUMNS = 20;
    localparam int DEF_LINES   = 4;

    // queue depths
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // item kinds
    localparam logic [1:0] KIND_COMPARE = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;
    localparam logic [1:0] KIND_NIBBLE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BACKLIGHT_MASK = 2'd1;
    localparam logic [1:0] REG_SELECT_MASK    = 2'd2;
    localparam logic [1:0] REG_STROBE_MASK    = 2'd3;

    // configuration reset values
    localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd39;
    localparam logic [7:0] RST_BACKLIGHT_MASK = 8'h08;
    localparam logic [7:0] RST_SELECT_MASK    = 8'h01;
    localparam logic [7:0] RST_STROBE_MASK    = 8'h04;

    // set ddram address command and nibble mask
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] NIBBLE_MASK  = 8'hF0;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] backlight_mask;
        logic [7:0] select_mask;
        logic [7:0] strobe_mask;
    } t_cfg;

    // one unit of work for the back end: up to two bytes, 1 to 4 nibbles
    typedef struct packed {
        logic [7:0] byte_hi;
        logic       data_hi;
        logic [7:0] byte_lo;
        logic       data_lo;
        logic [1:0] last_nib;
    } t_job;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [7:0] expander_byte;
        logic       frame_end;
        logic       last;
    } t_result;

    function automatic logic [7:0] row_base(input logic [1:0] line);
        logic [7:0] base;
        unique case (line)
            2'd0: base = 8'h00;
            2'd1: base = 8'h40;
            2'd2: base = 8'h14;
            2'd3: base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

FILE: design/cldw_queue.sv
`timescale 1ns / 1ps

module cldw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/cldw_front.sv
`timescale 1ns / 1ps

module cldw_front #(
    parameter int COLUMNS = 20,
    parameter int LINES   = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_kind,
    input  logic [1:0]    i_line_index,
    input  logic [4:0]    i_column,
    input  logic [7:0]    i_previous_char,
    input  logic [7:0]    i_new_char,
    input  logic          i_force_write,
    input  logic [7:0]    i_raw_value,
    input  logic          i_job_full,
    output logic          o_job_push,
    output cldw_pkg::t_job o_job
);
    import cldw_pkg::*;

    localparam logic [2:0] LINES_W   = 3'(LINES);
    localparam logic [5:0] COLUMNS_W = 6'(COLUMNS);

    logic       r_cursor_known, n_cursor_known;
    logic [1:0] r_cursor_line, n_cursor_line;
    logic [4:0] r_cursor_column, n_cursor_column;

    logic       accept;
    logic       in_range;
    logic       known_eff;
    logic       hit;
    logic       changed;
    logic [7:0] addr_cmd;
    logic [7:0] addr_sum;

    assign accept    = i_push && !i_job_full;
    assign in_range  = ({1'b0, i_line_index} < LINES_W) && ({1'b0, i_column} < COLUMNS_W);
    // column zero restarts tracking
    assign known_eff = r_cursor_known && (i_column != '0);
    assign hit       = known_eff && (r_cursor_line == i_line_index)
                       && (r_cursor_column == i_column);
    assign changed   = i_force_write || (i_previous_char != i_new_char);
    assign addr_sum  = row_base(i_line_index) + {3'b000, i_column};
    assign addr_cmd  = CMD_SET_ADDR | {1'b0, addr_sum[6:0]};

    always_comb begin
        o_job_push      = 1'b0;
        o_job.byte_hi   = i_raw_value;
        o_job.data_hi   = 1'b0;
        o_job.byte_lo   = i_new_char;
        o_job.data_lo   = 1'b1;
        o_job.last_nib  = 2'd1;
        n_cursor_known  = r_cursor_known;
        n_cursor_line   = r_cursor_line;
        n_cursor_column = r_cursor_column;
        unique case (i_kind)
            KIND_COMPARE: begin
                if (in_range && changed) begin
                    o_job_push = accept;
                    if (hit) begin
                        o_job.byte_hi  = i_new_char;
                        o_job.data_hi  = 1'b1;
                        o_job.last_nib = 2'd1;
                    end else begin
                        o_job.byte_hi  = addr_cmd;
                        o_job.data_hi  = 1'b0;
                        o_job.last_nib = 2'd3;
                    end
                    n_cursor_known  = 1'b1;
                    n_cursor_line   = i_line_index;
                    n_cursor_column = i_column + 5'd1;
                end else if (in_range) begin
                    n_cursor_known = known_eff;
                end
            end
            KIND_COMMAND: begin
                o_job_push     = accept;
                n_cursor_known = 1'b0;
            end
            KIND_DATA: begin
                o_job_push     = accept;
                o_job.data_hi  = 1'b1;
                n_cursor_known = 1'b0;
            end
            KIND_NIBBLE: begin
                o_job_push     = accept;
                o_job.last_nib = 2'd0;
                n_cursor_known = 1'b0;
            end
            default: begin
                o_job_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_known  <= 1'b0;
            r_cursor_line   <= '0;
            r_cursor_column <= '0;
        end else if (accept) begin
            r_cursor_known  <= n_cursor_known;
            r_cursor_line   <= n_cursor_line;
            r_cursor_column <= n_cursor_column;
        end
    end

endmodule

FILE: design/cldw_back.sv
`timescale 1ns / 1ps

module cldw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cldw_pkg::t_cfg    i_cfg,
    input  cldw_pkg::t_job    i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output cldw_pkg::t_result o_res
);
    import cldw_pkg::*;

    // position inside one three-byte frame
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_TAIL   = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_nib, n_nib;

    logic       emit;
    logic       last_res;
    logic [7:0] cur_byte;
    logic       cur_data;
    logic [7:0] nib_bits;
    logic [7:0] base;

    assign emit     = !i_job_empty && !i_res_full;
    assign cur_byte = r_nib[1] ? i_job.byte_lo : i_job.byte_hi;
    assign cur_data = r_nib[1] ? i_job.data_lo : i_job.data_hi;
    // high nibble first
    assign nib_bits = r_nib[0] ? {cur_byte[3:0], 4'b0000} : (cur_byte & NIBBLE_MASK);
    assign base     = nib_bits | i_cfg.backlight_mask | (cur_data ? i_cfg.select_mask : 8'h00);
    assign last_res = (r_phase == PH_TAIL) && (r_nib == i_job.last_nib);

    assign o_res_push          = emit;
    assign o_job_pop           = emit && last_res;
    assign o_res.bus_address   = i_cfg.device_address;
    assign o_res.expander_byte = (r_phase == PH_STROBE) ? (base | i_cfg.strobe_mask) : base;
    assign o_res.frame_end     = (r_phase == PH_TAIL);
    assign o_res.last          = last_res;

    always_comb begin
        n_phase = r_phase;
        n_nib   = r_nib;
        if (emit) begin
            unique case (r_phase)
                PH_LEAD:   n_phase = PH_STROBE;
                PH_STROBE: n_phase = PH_TAIL;
                PH_TAIL: begin
                    n_phase = PH_LEAD;
                    n_nib   = last_res ? 2'd0 : r_nib + 2'd1;
                end
                default: n_phase = PH_LEAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_nib   <= '0;
        end else begin
            r_phase <= n_phase;
            r_nib   <= n_nib;
        end
    end

endmodule

FILE: design/char_lcd_diff_update_writer.sv
`timescale 1ns / 1ps

// character lcd writer through an i2c port expander, 4-bit bus mode
// input channel: queue style, push/full; a transfer happens when push is high
//   and full is low. kinds: character compare, command byte, data byte, nibble
// result channel: queue style, empty/pop; the oldest expander byte sits on the
//   result ports while empty is low, a transfer happens when pop is high
// each nibble is three expander bytes (strobe low, high, low), frame_end marks
//   the third; last marks the final byte of an item
// an item gives 0, 3, 6 or 12 results; the back end emits one per cycle while a job
//   waits and the result queue is not full, and items that give nothing are
//   dropped by the front end and never enter the job queue
// the first result of an item passes the job queue and the result queue
//   registers before it shows on the result ports and can be popped
// the front end keeps the cursor and classifies; a 4-deep job queue lets it run
//   ahead of the back end, and a 2-deep result queue decouples the receiver
// when the receiver stalls, results collect in the result queue, then the job
//   queue fills and full rises
// configuration writes take effect at the next edge, write only while idle
// reset: synchronous, active low; clears the queues, the cursor tracking and
//   restores the registers (address 39, backlight 0x08, select 0x01,
//   strobe 0x04)
module char_lcd_diff_update_writer #(
    parameter int COLUMNS = cldw_pkg::DEF_COLUMNS,
    parameter int LINES   = cldw_pkg::DEF_LINES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_kind,
    input  logic [1:0] i_line_index,
    input  logic [4:0] i_column,
    input  logic [7:0] i_previous_char,
    input  logic [7:0] i_new_char,
    input  logic       i_force_write,
    input  logic [7:0] i_raw_value,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // result channel
    output logic       o_empty,
    input  logic       i_pop,
    output logic [6:0] o_bus_address,
    output logic [7:0] o_expander_byte,
    output logic       o_frame_end,
    output logic       o_last
);
    import cldw_pkg::*;

    // configuration registers
    t_cfg    r_cfg;

    // front to job queue
    logic    job_push;
    t_job    job_in;
    logic    job_full;
    // job queue to back end
    t_job    job_head;
    logic    job_empty;
    logic    job_pop;
    // back end to result queue
    logic    res_push;
    t_result res_in;
    logic    res_full;
    t_result res_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.backlight_mask <= RST_BACKLIGHT_MASK;
            r_cfg.select_mask    <= RST_SELECT_MASK;
            r_cfg.strobe_mask    <= RST_STROBE_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                REG_BACKLIGHT_MASK: r_cfg.backlight_mask <= i_cfg_data;
                REG_SELECT_MASK:    r_cfg.select_mask    <= i_cfg_data;
                REG_STROBE_MASK:    r_cfg.strobe_mask    <= i_cfg_data;
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // front: cursor tracking and item classification
    cldw_front #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_kind          (i_kind),
        .i_line_index    (i_line_index),
        .i_column        (i_column),
        .i_previous_char (i_previous_char),
        .i_new_char      (i_new_char),
        .i_force_write   (i_force_write),
        .i_raw_value     (i_raw_value),
        .i_job_full      (job_full),
        .o_job_push      (job_push),
        .o_job           (job_in)
    );

    // decoupling queue of classified jobs
    cldw_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    // back: nibble and strobe sequencing
    cldw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue toward the receiver
    cldw_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_head),
        .o_empty (o_empty)
    );

    assign o_full          = job_full;
    assign o_bus_address   = res_head.bus_address;
    assign o_expander_byte = res_head.expander_byte;
    assign o_frame_end     = res_head.frame_end;
    assign o_last          = res_head.last;

endmodule

FILE: design/cldw_checker.sv
`timescale 1ns / 1ps

module cldw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pop,
    input logic       o_empty,
    input logic [7:0] o_expander_byte,
    input logic       o_frame_end,
    input logic       o_last
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // the last byte of an item always closes a frame
    a_last_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> o_frame_end)
        else $error("last result without frame end");

    // results of one item follow without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last) |=> !o_empty)
        else $error("gap inside the results of one item");

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_expander_byte)))
        else $error("stalled result changed");

endmodule

bind char_lcd_diff_update_writer cldw_checker u_cldw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pop           (i_pop),
    .o_empty         (o_empty),
    .o_expander_byte (o_expander_byte),
    .o_frame_end     (o_frame_end),
    .o_last          (o_last)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

import cldw_pkg::*;

// one input transfer, field by field
typedef struct packed {
    logic [1:0] kind;
    logic [1:0] line_index;
    logic [4:0] column;
    logic [7:0] previous_char;
    logic [7:0] new_char;
    logic       force_write;
    logic [7:0] raw_value;
} t_lcd_item;

// predicts the expander byte stream and checks what the block returns
class lcd_frame_board;
    t_result    expected_bytes[$];
    t_cfg       regs;
    bit         cursor_known;
    logic [1:0] cursor_line;
    logic [4:0] cursor_column;
    int         errors;

    function new();
        regs.device_address = RST_DEVICE_ADDRESS;
        regs.backlight_mask = RST_BACKLIGHT_MASK;
        regs.select_mask    = RST_SELECT_MASK;
        regs.strobe_mask    = RST_STROBE_MASK;
        cursor_known  = 1'b0;
        cursor_line   = '0;
        cursor_column = '0;
        errors        = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    // ddram start address of each display line
    function logic [7:0] line_origin(logic [1:0] ln);
        case (ln)
            2'd0:    return 8'h00;
            2'd1:    return 8'h40;
            2'd2:    return 8'h14;
            default: return 8'h54;
        endcase
    endfunction

    // three expander bytes per nibble: strobe low, high, low
    function void add_nibble(logic [7:0] hi_bits, bit is_data, bit fin);
        t_result    r;
        logic [7:0] base;
        base = (hi_bits & NIBBLE_MASK) | regs.backlight_mask |
               (is_data ? regs.select_mask : 8'h00);
        for (int i = 0; i < 3; i++) begin
            r.bus_address   = regs.device_address;
            r.expander_byte = (i == 1) ? (base | regs.strobe_mask) : base;
            r.frame_end     = (i == 2);
            r.last          = fin && (i == 2);
            expected_bytes.push_back(r);
        end
    endfunction

    function void add_byte(logic [7:0] value, bit is_data, bit fin);
        add_nibble(value & NIBBLE_MASK, is_data, 1'b0);
        add_nibble({value[3:0], 4'h0}, is_data, fin);
    endfunction

    // returns how many expander bytes the item is to produce
    function int note_item(t_lcd_item it);
        int         before_count;
        logic [7:0] addr_cmd;
        before_count = expected_bytes.size();
        case (it.kind)
            KIND_COMPARE: begin
                // off-screen positions are dropped without touching the cursor
                if (it.line_index < DEF_LINES && it.column < DEF_COLUMNS) begin
                    if (it.column == 5'd0) cursor_known = 1'b0;
                    if (it.force_write || it.previous_char != it.new_char) begin
                        if (!(cursor_known && cursor_line == it.line_index &&
                              cursor_column == it.column)) begin
                            addr_cmd = CMD_SET_ADDR |
                                       ((line_origin(it.line_index) + 8'(it.column)) & 8'h7F);
                            add_byte(addr_cmd, 1'b0, 1'b0);
                        end
                        add_byte(it.new_char, 1'b1, 1'b1);
                        cursor_known  = 1'b1;
                        cursor_line   = it.line_index;
                        cursor_column = it.column + 5'd1;
                    end
                end
            end
            KIND_COMMAND: begin
                add_byte(it.raw_value, 1'b0, 1'b1);
                cursor_known = 1'b0;
            end
            KIND_DATA: begin
                add_byte(it.raw_value, 1'b1, 1'b1);
                cursor_known = 1'b0;
            end
            default: begin
                add_nibble(it.raw_value & NIBBLE_MASK, 1'b0, 1'b1);
                cursor_known = 1'b0;
            end
        endcase
        return expected_bytes.size() - before_count;
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected result: address %0d byte %02h", got.bus_address,
                   got.expander_byte);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.bus_address !== want.bus_address) begin
            $error("bus_address: expected %0d actual %0d", want.bus_address, got.bus_address);
            errors++;
        end
        if (got.expander_byte !== want.expander_byte) begin
            $error("expander_byte: expected %02h actual %02h", want.expander_byte,
                   got.expander_byte);
            errors++;
        end
        if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b actual %0b", want.frame_end, got.frame_end);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;

    // receiver hold-off that forces the queues to fill up
    localparam int HOLD_CYCLES = 300;
    // idle cycles after the last expected result before the next phase
    localparam int SETTLE_CYCLES = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic       o_full;
    logic [1:0] i_kind = '0;
    logic [1:0] i_line_index = '0;
    logic [4:0] i_column = '0;
    logic [7:0] i_previous_char = '0;
    logic [7:0] i_new_char = '0;
    logic       i_force_write = 1'b0;
    logic [7:0] i_raw_value = '0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       o_empty;
    logic       i_pop = 1'b0;
    logic [6:0] o_bus_address;
    logic [7:0] o_expander_byte;
    logic       o_frame_end;
    logic       o_last;

    lcd_frame_board board = new();

    // idling ranges per side, changed between phases
    int  send_max_gap = 9;
    int  pop_max_gap = 9;
    // set by the stimulus, cleared by the receiver once it has held off
    bit  hold_request = 1'b0;

    char_lcd_diff_update_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_kind          (i_kind),
        .i_line_index    (i_line_index),
        .i_column        (i_column),
        .i_previous_char (i_previous_char),
        .i_new_char      (i_new_char),
        .i_force_write   (i_force_write),
        .i_raw_value     (i_raw_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_bus_address   (o_bus_address),
        .o_expander_byte (o_expander_byte),
        .o_frame_end     (o_frame_end),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // item builders
    function automatic t_lcd_item compare_item(logic [1:0] ln, logic [4:0] col,
                                               logic [7:0] prev, logic [7:0] want,
                                               logic frc);
        t_lcd_item it;
        it.kind          = KIND_COMPARE;
        it.line_index    = ln;
        it.column        = col;
        it.previous_char = prev;
        it.new_char      = want;
        it.force_write   = frc;
        it.raw_value     = 8'($urandom);
        return it;
    endfunction

    function automatic t_lcd_item noise_item();
        t_lcd_item it;
        it.kind          = 2'($urandom);
        it.line_index    = 2'($urandom);
        it.column        = 5'($urandom);
        it.previous_char = 8'($urandom);
        it.new_char      = 8'($urandom);
        it.force_write   = 1'($urandom);
        it.raw_value     = 8'($urandom);
        return it;
    endfunction

    // command, data or nibble; the compare fields carry noise
    function automatic t_lcd_item raw_item(logic [1:0] k, logic [7:0] value);
        t_lcd_item it;
        it           = noise_item();
        it.kind      = k;
        it.raw_value = value;
        return it;
    endfunction

    // offer one item after a random gap and count it once it is taken
    task automatic send_item(input t_lcd_item it, inout int done);
        int gap;
        gap = $urandom_range(0, send_max_gap);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind          <= it.kind;
        i_line_index    <= it.line_index;
        i_column        <= it.column;
        i_previous_char <= it.previous_char;
        i_new_char      <= it.new_char;
        i_force_write   <= it.force_write;
        i_raw_value     <= it.raw_value;
        i_push          <= 1'b1;
        do @(posedge i_clk); while (o_full);
        // transfer taken at this edge
        void'(board.note_item(it));
        done++;
    endtask

    // run of compare items along one line, mostly consecutive columns
    task automatic line_run(inout int done);
        t_lcd_item  it;
        int         len;
        logic [1:0] ln;
        logic [4:0] col;
        len = $urandom_range(3, 10);
        ln  = 2'($urandom);
        col = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 19));
        repeat (len) begin
            it = compare_item(ln, col, 8'($urandom), 8'($urandom), ($urandom_range(0, 5) == 0));
            // unchanged character, written only when forced
            if ($urandom_range(0, 4) == 0) it.new_char = it.previous_char;
            send_item(it, done);
            // an occasional skipped column or line jump breaks the tracking
            col = col + (($urandom_range(0, 7) == 0) ? 5'd2 : 5'd1);
            if ($urandom_range(0, 11) == 0) ln = 2'($urandom);
        end
    endtask

    task automatic random_items(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) line_run(done);
            else if (pick < 8) send_item(raw_item(2'($urandom_range(1, 3)), 8'($urandom)), done);
            else send_item(noise_item(), done);
        end
    endtask

    task automatic directed_items();
        int done;
        done = 0;
        // raw kinds at both extremes, nibble takes only the upper bits
        send_item(raw_item(KIND_COMMAND, 8'h00), done);
        send_item(raw_item(KIND_COMMAND, 8'hFF), done);
        send_item(raw_item(KIND_DATA, 8'h00), done);
        send_item(raw_item(KIND_DATA, 8'hFF), done);
        send_item(raw_item(KIND_NIBBLE, 8'hF0), done);
        send_item(raw_item(KIND_NIBBLE, 8'h0F), done);
        // column zero restart, then the tracked cursor skips the address
        send_item(compare_item(2'd0, 5'd0, 8'h20, 8'h41, 1'b0), done);
        send_item(compare_item(2'd0, 5'd1, 8'h20, 8'h42, 1'b0), done);
        // unchanged without force, then forced
        send_item(compare_item(2'd0, 5'd2, 8'h55, 8'h55, 1'b0), done);
        send_item(compare_item(2'd0, 5'd2, 8'h55, 8'h55, 1'b1), done);
        send_item(compare_item(2'd0, 5'd3, 8'h00, 8'hFF, 1'b0), done);
        // last line and column, then positions off the screen
        send_item(compare_item(2'd3, 5'd19, 8'hFF, 8'h00, 1'b0), done);
        send_item(compare_item(2'd3, 5'd20, 8'h00, 8'h33, 1'b1), done);
        send_item(compare_item(2'd2, 5'd31, 8'h00, 8'h33, 1'b1), done);
        send_item(compare_item(2'd3, 5'd20, 8'h10, 8'h11, 1'b0), done);
        // unchanged at column zero still drops the tracking
        send_item(compare_item(2'd1, 5'd0, 8'h30, 8'h31, 1'b0), done);
        send_item(compare_item(2'd1, 5'd1, 8'h30, 8'h31, 1'b0), done);
        send_item(compare_item(2'd1, 5'd0, 8'h61, 8'h61, 1'b0), done);
        send_item(compare_item(2'd1, 5'd2, 8'h30, 8'h32, 1'b0), done);
        // raw item in between forgets the cursor
        send_item(raw_item(KIND_COMMAND, 8'h01), done);
        send_item(compare_item(2'd1, 5'd3, 8'h30, 8'h33, 1'b0), done);
        // other line, same column
        send_item(compare_item(2'd2, 5'd4, 8'h30, 8'h34, 1'b0), done);
        send_item(compare_item(2'd2, 5'd5, 8'h30, 8'h35, 1'b1), done);
    endtask

    // stop offering, drain every expected byte, then idle for SETTLE_CYCLES
    task automatic settle_block();
        i_push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg cfg);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_DEVICE_ADDRESS;
        i_cfg_data  <= {1'b0, cfg.device_address};
        @(posedge i_clk);
        i_cfg_index <= REG_BACKLIGHT_MASK;
        i_cfg_data  <= cfg.backlight_mask;
        @(posedge i_clk);
        i_cfg_index <= REG_SELECT_MASK;
        i_cfg_data  <= cfg.select_mask;
        @(posedge i_clk);
        i_cfg_index <= REG_STROBE_MASK;
        i_cfg_data  <= cfg.strobe_mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.regs = cfg;
    endtask

    // result side: pops with random gaps, holds off on request
    initial begin : result_sink
        int      gap;
        t_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            gap = $urandom_range(0, pop_max_gap);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            // transfer taken at this edge
            got.bus_address   = o_bus_address;
            got.expander_byte = o_expander_byte;
            got.frame_end     = o_frame_end;
            got.last          = o_last;
            board.check_result(got);
        end
    end

    initial begin : stimulus
        t_cfg cfg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        directed_items();
        random_items(45);

        // everything zero, receiver holds off while items keep coming
        settle_block();
        cfg = '0;
        program_regs(cfg);
        send_max_gap = 1;
        hold_request = 1'b1;
        random_items(45);

        // everything at its maximum, no idling on either side
        settle_block();
        cfg.device_address = 7'h7F;
        cfg.backlight_mask = 8'hFF;
        cfg.select_mask    = 8'hFF;
        cfg.strobe_mask    = 8'hFF;
        program_regs(cfg);
        send_max_gap = 0;
        pop_max_gap  = 0;
        random_items(40);

        // masks overlapping each other and the nibble bits
        settle_block();
        cfg.device_address = 7'($urandom);
        cfg.backlight_mask = 8'h3C;
        cfg.select_mask    = 8'h0F;
        cfg.strobe_mask    = 8'hC3;
        program_regs(cfg);
        send_max_gap = 9;
        pop_max_gap  = 9;
        random_items(40);

        // random registers, fast receiver
        settle_block();
        cfg = t_cfg'(31'($urandom));
        program_regs(cfg);
        send_max_gap = 9;
        pop_max_gap  = 3;
        random_items(50);

        settle_block();
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
